// ----- rtl/core/toq_pkg.sv -----
// ---------------------------------------------------------------------------
// toq_pkg
// Shared types and codes for the throttled order queue.
// ---------------------------------------------------------------------------
package toq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int TIME_W          = 17;
    localparam int LIMIT_W         = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 17;

    // Request modes.
    localparam logic [1:0] MODE_NEW    = 2'd0;
    localparam logic [1:0] MODE_MODIFY = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_SENT     = 3'd0;
    localparam logic [2:0] KIND_LOGON    = 3'd1;
    localparam logic [2:0] KIND_LOGOUT   = 3'd2;
    localparam logic [2:0] KIND_REJECTED = 3'd3;
    localparam logic [2:0] KIND_DROPPED  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_SESSION_START = 2'd0;
    localparam logic [1:0] REG_SESSION_END   = 2'd1;
    localparam logic [1:0] REG_MAX_SENDS     = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [63:0]       order_id;
        logic [31:0]       order_price;
        logic [31:0]       order_qty;
        logic [TIME_W-1:0] time_of_day;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] out_order_id;
        logic [31:0] out_price;
        logic [31:0] out_qty;
        logic        last;
    } out_beat_t;

    typedef struct packed {
        logic [63:0] id;
        logic [31:0] price;
        logic [31:0] qty;
    } entry_t;

    // Per-cycle command broadcast to every cell of the queue.
    typedef struct packed {
        logic shift;  // take the right neighbor's entry
        logic ins;    // the cell at the insert position loads the insert entry
    } cell_ctl_t;

endpackage

// ----- rtl/core/throttled_order_queue_unit.sv -----
// ---------------------------------------------------------------------------
// throttled_order_queue_unit
// Order queue drained by a fixed-window rate limiter, built as a row of cells.
// ---------------------------------------------------------------------------
//  Channel   Ports                              Beat
//  input     s_valid / s_ready / s_data         one request or one-second tick
//  result    m_valid / m_ready / m_data         sent, logon, logout, reject, drop
//  config    cfg_wr_en / cfg_index / cfg_wr_data  register write, no wait
//
// An item is taken only while the sequencer is idle. After it is accepted, the
// request is decoded; a modify or cancel then rotates the queue through the cell
// row, a new order (or a modify that found no match) is appended, and the drain
// sends orders from the head. A tick goes from decode straight to the drain, and
// an off-session request is rejected in decode and returns to idle.
// Every cycle that wants to present a result waits while the output register holds
// an unaccepted beat. Reset clears the count, send counter, session flag and output
// valid; the cell contents are left as they are.
module throttled_order_queue_unit #(
    parameter int QUEUE_DEPTH = toq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  toq_pkg::in_beat_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output toq_pkg::out_beat_t             m_data,
    input  logic                           cfg_wr_en,
    input  logic [toq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [toq_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TW    = toq_pkg::TIME_W;
    localparam int LW    = toq_pkg::LIMIT_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_PUSH  = 5'b01000,
        ST_DRAIN = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [TW-1:0] start_reg, end_reg;
    logic [LW-1:0] max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            end_reg   <= TW'(86399);
            max_reg   <= LW'(100);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                toq_pkg::REG_SESSION_START: start_reg <= cfg_wr_data[TW-1:0];
                toq_pkg::REG_SESSION_END:   end_reg   <= cfg_wr_data[TW-1:0];
                toq_pkg::REG_MAX_SENDS:     max_reg   <= cfg_wr_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Control state.
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [LW-1:0]    sent_reg, sent_next;
    logic             active_reg, active_next;
    logic             found_reg, found_next;
    toq_pkg::in_beat_t req_reg;

    // Output register.
    logic               m_valid_reg;
    toq_pkg::out_beat_t m_data_reg;
    logic               out_load;
    toq_pkg::out_beat_t out_next;
    logic               stall;

    // Cell row.
    toq_pkg::entry_t   cell_q [QUEUE_DEPTH];
    toq_pkg::entry_t   ins_d;
    toq_pkg::entry_t   head;
    toq_pkg::cell_ctl_t ctl;
    logic [IDX_W-1:0]  ins_pos;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            toq_pkg::entry_t right_d;
            if (g == QUEUE_DEPTH - 1) begin : g_end
                assign right_d = cell_q[g];
            end else begin : g_mid
                assign right_d = cell_q[g+1];
            end
            toq_cell #(
                .IDX   (g),
                .IDX_W (IDX_W)
            ) u_cell (
                .aclk    (aclk),
                .ctl     (ctl),
                .ins_pos (ins_pos),
                .ins_d   (ins_d),
                .right_d (right_d),
                .data    (cell_q[g])
            );
        end
    endgenerate

    assign head  = cell_q[0];
    assign stall = m_valid_reg && !m_ready;

    logic in_window;
    logic head_match;
    logic full;
    logic sent_room;
    logic more_after_send;

    assign in_window  = (req_reg.time_of_day >= start_reg) && (req_reg.time_of_day <= end_reg);
    assign head_match = (head.id == req_reg.order_id);
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign sent_room  = (sent_reg < max_reg);
    // After sending the head, another send follows when entries and budget remain.
    assign more_after_send = (count_reg > CNT_W'(1))
                          && (({1'b0, sent_reg} + 1'b1) < {1'b0, max_reg});

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        sent_next   = sent_reg;
        active_next = active_reg;
        found_next  = found_reg;
        out_load    = 1'b0;
        out_next    = '0;
        ctl         = '0;
        ins_pos     = IDX_W'(count_reg);
        ins_d.id    = req_reg.order_id;
        ins_d.price = req_reg.order_price;
        ins_d.qty   = req_reg.order_qty;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                if (req_reg.mode == toq_pkg::MODE_TICK) begin
                    if (in_window != active_reg) begin
                        if (!stall) begin
                            out_load          = 1'b1;
                            out_next.kind     = in_window ? toq_pkg::KIND_LOGON
                                                          : toq_pkg::KIND_LOGOUT;
                            // A logon is followed by sends when orders wait and the
                            // limit allows any.
                            out_next.last     = !(in_window && (count_reg != '0)
                                                  && (max_reg != '0));
                            active_next       = in_window;
                            sent_next         = '0;
                            state_next        = ST_DRAIN;
                        end
                    end else begin
                        sent_next  = '0;
                        state_next = ST_DRAIN;
                    end
                end else if (!active_reg) begin
                    if (!stall) begin
                        out_load              = 1'b1;
                        out_next.kind         = toq_pkg::KIND_REJECTED;
                        out_next.out_order_id = req_reg.order_id;
                        out_next.last         = 1'b1;
                        state_next            = ST_IDLE;
                    end
                end else if (req_reg.mode == toq_pkg::MODE_NEW) begin
                    state_next = ST_PUSH;
                end else begin
                    left_next  = count_reg;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            // The head leaves the front each cycle and, unless cancelled, goes
            // back in at the tail, so after count steps the order is restored.
            ST_SCAN: begin
                if (left_reg == '0) begin
                    state_next = ((req_reg.mode == toq_pkg::MODE_MODIFY) && !found_reg)
                               ? ST_PUSH : ST_DRAIN;
                end else begin
                    left_next = left_reg - 1'b1;
                    ctl.shift = 1'b1;
                    ins_pos   = IDX_W'(count_reg - 1'b1);
                    ins_d     = head;
                    if (req_reg.mode == toq_pkg::MODE_MODIFY) begin
                        ctl.ins = 1'b1;
                        if (head_match) begin
                            ins_d.price = req_reg.order_price;
                            ins_d.qty   = req_reg.order_qty;
                            found_next  = 1'b1;
                        end
                    end else if (head_match) begin
                        count_next = count_reg - 1'b1;
                    end else begin
                        ctl.ins = 1'b1;
                    end
                end
            end

            ST_PUSH: begin
                if (full) begin
                    if (!stall) begin
                        out_load              = 1'b1;
                        out_next.kind         = toq_pkg::KIND_DROPPED;
                        out_next.out_order_id = req_reg.order_id;
                        out_next.last         = !sent_room;
                        state_next            = ST_DRAIN;
                    end
                end else begin
                    ctl.ins    = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN: begin
                if ((count_reg != '0) && active_reg && sent_room) begin
                    if (!stall) begin
                        out_load              = 1'b1;
                        out_next.kind         = toq_pkg::KIND_SENT;
                        out_next.out_order_id = head.id;
                        out_next.out_price    = head.price;
                        out_next.out_qty      = head.qty;
                        out_next.last         = !more_after_send;
                        ctl.shift             = 1'b1;
                        count_next            = count_reg - 1'b1;
                        sent_next             = sent_reg + 1'b1;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            left_reg    <= '0;
            sent_reg    <= '0;
            active_reg  <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            left_reg   <= left_next;
            sent_reg   <= sent_next;
            active_reg <= active_next;
            found_reg  <= found_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/core/toq_cell.sv -----
// ---------------------------------------------------------------------------
// toq_cell
// One queue slot: holds an entry, shifts toward the front or loads an insert.
// ---------------------------------------------------------------------------
module toq_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 5
) (
    input  logic               aclk,
    input  toq_pkg::cell_ctl_t ctl,
    input  logic [IDX_W-1:0]   ins_pos,
    input  toq_pkg::entry_t    ins_d,
    input  toq_pkg::entry_t    right_d,
    output toq_pkg::entry_t    data
);

    toq_pkg::entry_t data_reg;

    // An insert at this slot wins over the shift.
    always_ff @(posedge aclk) begin
        if (ctl.ins && (ins_pos == IDX_W'(IDX))) begin
            data_reg <= ins_d;
        end else if (ctl.shift) begin
            data_reg <= right_d;
        end
    end

    assign data = data_reg;

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the throttled order queue unit.
// A queue of requests and ticks feeds a clocked driver. A clocked monitor
// checks every result beat against a behavioral copy of the order queue and
// its send limiter. Both sides idle at random but in the last phase, and the
// registers are rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = toq_pkg::QUEUE_DEPTH_DEF;
    localparam int TW    = toq_pkg::TIME_W;
    localparam int DW    = toq_pkg::CFG_DATA_W;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    toq_pkg::in_beat_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    toq_pkg::out_beat_t m_data;
    logic                           cfg_wr_en = 1'b0;
    logic [toq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DW-1:0]                  cfg_wr_data = '0;

    throttled_order_queue_unit #(.QUEUE_DEPTH(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Requests waiting for the driver, and report beats the block still owes.
    toq_pkg::in_beat_t  pending_requests[$];
    toq_pkg::out_beat_t owed_reports[$];
    int        failures = 0;
    int        requests_taken = 0;
    int        kind_seen[5];
    bit        no_idle = 1'b0;   // when set, neither side inserts gaps

    // Behavioral copy of the block: the order FIFO, the window count, the
    // session flag and the three registers.
    logic [63:0]   book_id[DEPTH];
    logic [31:0]   book_price[DEPTH];
    logic [31:0]   book_qty[DEPTH];
    int            book_count = 0;
    logic [15:0]   sent_in_window = '0;
    bit            logged_on = 1'b0;
    logic [TW-1:0] win_start = 17'd0;
    logic [TW-1:0] win_end = 17'd86399;
    logic [15:0]   send_limit = 16'd100;

    function automatic toq_pkg::out_beat_t report(logic [2:0] k, logic [63:0] id,
                                                  logic [31:0] p, logic [31:0] q);
        toq_pkg::out_beat_t r;
        r.kind = k;
        r.out_order_id = id;
        r.out_price = p;
        r.out_qty = q;
        r.last = 1'b0;
        return r;
    endfunction

    // Appends an order at the tail, or reports it dropped when the FIFO is full.
    function automatic void enqueue_order(ref toq_pkg::out_beat_t r[$],
                                          input logic [63:0] id,
                                          input logic [31:0] p, input logic [31:0] q);
        if (book_count >= DEPTH) begin
            r.push_back(report(toq_pkg::KIND_DROPPED, id, '0, '0));
        end else begin
            book_id[book_count] = id;
            book_price[book_count] = p;
            book_qty[book_count] = q;
            book_count++;
        end
    endfunction

    // Works out every report one accepted beat causes and updates the copy.
    function automatic void forecast_reports(toq_pkg::in_beat_t b);
        toq_pkg::out_beat_t r[$];
        bit        in_window;
        bit        matched;
        int        w;
        if (b.mode == toq_pkg::MODE_TICK) begin
            in_window = b.time_of_day >= win_start && b.time_of_day <= win_end;
            sent_in_window = '0;
            if (in_window && !logged_on) begin
                logged_on = 1'b1;
                r.push_back(report(toq_pkg::KIND_LOGON, '0, '0, '0));
            end else if (!in_window && logged_on) begin
                logged_on = 1'b0;
                r.push_back(report(toq_pkg::KIND_LOGOUT, '0, '0, '0));
            end
        end else if (!logged_on) begin
            r.push_back(report(toq_pkg::KIND_REJECTED, b.order_id, '0, '0));
        end else if (b.mode == toq_pkg::MODE_NEW) begin
            enqueue_order(r, b.order_id, b.order_price, b.order_qty);
        end else if (b.mode == toq_pkg::MODE_MODIFY) begin
            matched = 1'b0;
            for (int i = 0; i < book_count; i++) begin
                if (book_id[i] == b.order_id) begin
                    book_price[i] = b.order_price;
                    book_qty[i] = b.order_qty;
                    matched = 1'b1;
                end
            end
            if (!matched) enqueue_order(r, b.order_id, b.order_price, b.order_qty);
        end else begin
            w = 0;
            for (int i = 0; i < book_count; i++) begin
                if (book_id[i] != b.order_id) begin
                    book_id[w] = book_id[i];
                    book_price[w] = book_price[i];
                    book_qty[w] = book_qty[i];
                    w++;
                end
            end
            book_count = w;
        end
        // Release from the front while the window still has room.
        while (book_count > 0 && logged_on && sent_in_window < send_limit) begin
            r.push_back(report(toq_pkg::KIND_SENT, book_id[0], book_price[0],
                               book_qty[0]));
            for (int i = 1; i < book_count; i++) begin
                book_id[i-1] = book_id[i];
                book_price[i-1] = book_price[i];
                book_qty[i-1] = book_qty[i];
            end
            book_count--;
            sent_in_window = sent_in_window + 16'd1;
        end
        if (r.size() > 0) r[r.size()-1].last = 1'b1;
        foreach (r[i]) owed_reports.push_back(r[i]);
    endfunction

    // Driver: takes the next request from the queue once the current beat has
    // gone, after a random number of idle cycles drawn per beat.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                forecast_reports(s_data);
                requests_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    s_data <= pending_requests.pop_front();
                    s_valid <= 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 8);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest owed report and
    // stalls the result channel for a random count drawn per beat.
    int                 stall_left = 0;
    toq_pkg::out_beat_t want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                stall_left = no_idle ? 0 : $urandom_range(0, 8);
                if (owed_reports.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %p",
                             $time, m_data);
                    failures++;
                end else begin
                    want = owed_reports.pop_front();
                    if (m_data.kind <= toq_pkg::KIND_DROPPED) kind_seen[m_data.kind]++;
                    if (m_data.kind != want.kind) begin
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, want.kind, m_data.kind);
                        failures++;
                    end
                    if (m_data.out_order_id != want.out_order_id) begin
                        $display("%0t: order id expected %h actual %h",
                                 $time, want.out_order_id, m_data.out_order_id);
                        failures++;
                    end
                    if (m_data.out_price != want.out_price) begin
                        $display("%0t: price expected %h actual %h",
                                 $time, want.out_price, m_data.out_price);
                        failures++;
                    end
                    if (m_data.out_qty != want.out_qty) begin
                        $display("%0t: qty expected %h actual %h",
                                 $time, want.out_qty, m_data.out_qty);
                        failures++;
                    end
                    if (m_data.last != want.last) begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, m_data.last);
                        failures++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic toq_pkg::in_beat_t request(logic [1:0] m, logic [63:0] id,
                                                  logic [31:0] p, logic [31:0] q,
                                                  logic [TW-1:0] t);
        toq_pkg::in_beat_t b;
        b.mode = m;
        b.order_id = id;
        b.order_price = p;
        b.order_qty = q;
        b.time_of_day = t;
        return b;
    endfunction

    function automatic toq_pkg::in_beat_t tick_at(logic [TW-1:0] t);
        return request(toq_pkg::MODE_TICK, {$urandom, $urandom}, $urandom, $urandom, t);
    endfunction

    // Waits until every request is taken and every report is in, then lets
    // the block finish any silent work (a scan of a full queue plus a drain).
    task automatic settle();
        while (pending_requests.size() > 0 || s_valid || owed_reports.size() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(logic [toq_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            toq_pkg::REG_SESSION_START: win_start = val;
            toq_pkg::REG_SESSION_END:   win_end = val;
            default:                    send_limit = val[15:0];
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_session(int s, int e, int lim);
        write_reg(toq_pkg::REG_SESSION_START, DW'(s));
        write_reg(toq_pkg::REG_SESSION_END, DW'(e));
        write_reg(toq_pkg::REG_MAX_SENDS, DW'(lim));
    endtask

    logic [63:0] id_pool[8];

    // A random request built around a small pool of ids, so that modify and
    // cancel often hit queued orders; ticks land inside the window half the time.
    function automatic toq_pkg::in_beat_t random_request();
        int            r;
        logic [63:0]   id;
        logic [TW-1:0] t;
        r = $urandom_range(0, 9);
        id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                          : id_pool[$urandom_range(0, 7)];
        if (r >= 8) begin
            if ($urandom_range(0, 1) && win_start <= win_end)
                t = TW'($urandom_range(win_start, win_end));
            else
                t = TW'($urandom);
            return tick_at(t);
        end
        return request(r < 4 ? toq_pkg::MODE_NEW
                             : (r < 6 ? toq_pkg::MODE_MODIFY : toq_pkg::MODE_CANCEL),
                       id, $urandom, $urandom, TW'($urandom));
    endfunction

    initial begin
        int s;
        foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset window covers the whole day. A request before logon is
        // rejected, then orders at the field extremes go straight out.
        pending_requests.push_back(request(toq_pkg::MODE_NEW, '1, '1, '1, '1));
        pending_requests.push_back(tick_at(17'd0));
        pending_requests.push_back(request(toq_pkg::MODE_NEW, '0, '0, '0, '0));
        pending_requests.push_back(request(toq_pkg::MODE_NEW, '1, '1, '1, '0));
        pending_requests.push_back(request(toq_pkg::MODE_MODIFY, 64'h5a5a, 32'h1,
                                           32'h2, '0));
        pending_requests.push_back(request(toq_pkg::MODE_CANCEL, 64'h77, '0, '0, '0));
        settle();

        // Inclusive window edges, a time beyond the day, and a zero limit so
        // that the queue fills up.
        set_session(100, 200, 0);
        pending_requests.push_back(tick_at(17'd99));
        pending_requests.push_back(tick_at(17'd100));
        pending_requests.push_back(tick_at(17'd200));
        pending_requests.push_back(tick_at(17'd201));
        pending_requests.push_back(tick_at(17'h1ffff));
        pending_requests.push_back(tick_at(17'd150));
        for (int i = 0; i < DEPTH; i++)
            pending_requests.push_back(request(toq_pkg::MODE_NEW, id_pool[i % 4],
                                               $urandom, $urandom, '0));
        pending_requests.push_back(request(toq_pkg::MODE_NEW, id_pool[5], 1, 1, '0));
        pending_requests.push_back(request(toq_pkg::MODE_MODIFY, id_pool[6], 2, 2, '0));
        pending_requests.push_back(request(toq_pkg::MODE_MODIFY, id_pool[1], '1, '1,
                                           '0));
        pending_requests.push_back(request(toq_pkg::MODE_CANCEL, id_pool[2], '0, '0,
                                           '0));
        pending_requests.push_back(request(toq_pkg::MODE_CANCEL, id_pool[7], '0, '0,
                                           '0));
        settle();

        // A small limit releases part of the queue per tick, the top limit
        // the rest.
        write_reg(toq_pkg::REG_MAX_SENDS, 17'd3);
        pending_requests.push_back(tick_at(17'd150));
        settle();
        write_reg(toq_pkg::REG_MAX_SENDS, 17'hffff);
        pending_requests.push_back(tick_at(17'd160));
        settle();

        // One-second session at the end of the day, then an empty window.
        set_session(86399, 86399, 5);
        pending_requests.push_back(tick_at(17'd86399));
        pending_requests.push_back(tick_at(17'd0));
        settle();
        set_session(5, 4, 1);
        pending_requests.push_back(tick_at(17'd4));
        pending_requests.push_back(tick_at(17'd5));
        pending_requests.push_back(request(toq_pkg::MODE_CANCEL, '1, '0, '0, '0));
        settle();

        // Random phases, each under its own settings; the last one runs
        // without any idling.
        for (int ph = 0; ph < 4; ph++) begin
            s = $urandom_range(0, 80000);
            if (ph == 3) set_session(0, 86399, $urandom_range(0, 6));
            else if ($urandom_range(0, 4) == 0) set_session(s, s / 2, 2);
            else set_session(s, s + $urandom_range(0, 6000),
                             $urandom_range(0, 2) == 0 ? 16'hffff : $urandom_range(0, 5));
            no_idle = (ph == 3);
            if (win_start <= win_end)
                pending_requests.push_back(
                    tick_at(TW'($urandom_range(win_start, win_end))));
            for (int i = 0; i < 15; i++) pending_requests.push_back(random_request());
            settle();
        end

        $display("Took %0d requests; sent %0d orders, %0d logons, %0d logouts,",
                 requests_taken, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("%0d rejected off session, %0d dropped on a full queue.",
                 kind_seen[3], kind_seen[4]);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
